// ===== design/lra_pkg.sv =====
// Shared types and constants for the LIFO region allocator.
// Used by lra_core and lifo_region_allocator; no dependencies.
`default_nettype none

package lra_pkg;

    // Stack depth and owner tag width
    localparam int MAX_ALLOCS = 4;
    localparam int OWNER_BITS = 8;

    // Derived widths
    localparam int CNT_W   = $clog2(MAX_ALLOCS + 1);
    localparam int IDX_W   = (MAX_ALLOCS > 1) ? $clog2(MAX_ALLOCS) : 1;
    localparam int OWN_IN  = (OWNER_BITS < 8) ? OWNER_BITS : 8;

    localparam int ADDR_W  = 32;
    localparam int SIZE_W  = 23;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = 32;
    localparam int S_TDATA_W = 64;
    localparam int M_TDATA_W = 64;

    localparam logic [SIZE_W-1:0] FREE_MAX = {SIZE_W{1'b1}};

    typedef enum logic {
        OP_ALLOC   = 1'b0,
        OP_RELEASE = 1'b1
    } op_t;

    typedef enum logic [2:0] {
        ST_OK          = 3'd0,
        ST_NOT_READY   = 3'd1,
        ST_TOO_MANY    = 3'd2,
        ST_NO_MEMORY   = 3'd3,
        ST_MISALIGNED  = 3'd4,
        ST_WRONG_OWNER = 3'd5,
        ST_BELOW_FLOOR = 3'd6,
        ST_BAD_ORDER   = 3'd7
    } status_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_HEAP_ENABLE   = 2'd0,
        CFG_HEAP_BASE     = 2'd1,
        CFG_HEAP_SIZE     = 2'd2,
        CFG_RELEASE_FLOOR = 2'd3
    } cfg_idx_t;

    typedef struct packed {
        op_t                operation;
        logic [7:0]         owner_id;
        logic [SIZE_W-1:0]  request_size;
        logic [ADDR_W-1:0]  release_address;
    } req_t;

    typedef struct packed {
        status_t            status;
        logic [ADDR_W-1:0]  block_address;
        logic [SIZE_W-1:0]  free_bytes_left;
    } rsp_t;

    // Configuration write bundle
    typedef struct packed {
        logic                  we;
        logic [CFG_IDX_W-1:0]  index;
        logic [CFG_DATA_W-1:0] wdata;
    } cfg_wr_t;

endpackage

`default_nettype wire

// ===== design/lra_core.sv =====
// Allocator state and per-request decision logic for the LIFO region allocator.
// Holds heap registers, top/free/count state and the owner stack; uses lra_pkg.
`default_nettype none

module lra_core (
    input  wire logic            aclk,
    input  wire logic            aresetn,
    input  wire lra_pkg::cfg_wr_t cfg,
    input  wire logic            fire,
    input  wire lra_pkg::req_t   req,
    output lra_pkg::rsp_t        rsp
);
    import lra_pkg::*;

    // Configuration registers
    logic                 heap_enable_reg;
    logic [ADDR_W-1:0]    heap_base_reg;
    logic [SIZE_W-1:0]    heap_size_reg;
    logic [ADDR_W-1:0]    release_floor_reg;

    // Allocator state
    logic [ADDR_W-1:0]    top_reg, top_next;
    logic [SIZE_W-1:0]    free_reg, free_next;
    logic [CNT_W-1:0]     count_reg, count_next;
    logic [OWNER_BITS-1:0] owner_stack_reg [MAX_ALLOCS];

    logic                 ready;
    logic [OWNER_BITS-1:0] owner_in;
    logic [SIZE_W:0]      rounded;
    logic [IDX_W-1:0]     top_idx;
    logic [CNT_W-1:0]     count_dec;
    logic [ADDR_W-1:0]    span;
    logic [ADDR_W:0]      sum;
    logic                 push;

    assign ready     = heap_enable_reg && (heap_base_reg[1:0] == 2'b00);
    assign owner_in  = OWNER_BITS'(req.owner_id[OWN_IN-1:0]);
    assign rounded   = ({1'b0, req.request_size} + (SIZE_W+1)'(3)) & ~(SIZE_W+1)'(3);
    assign count_dec = count_reg - CNT_W'(1);
    assign top_idx   = count_dec[IDX_W-1:0];
    assign span      = top_reg - req.release_address;
    assign sum       = (ADDR_W+1)'(free_reg) + {1'b0, span};

    // Request decision and next state
    always_comb begin
        rsp.status          = ST_OK;
        rsp.block_address   = '0;
        top_next            = top_reg;
        free_next           = free_reg;
        count_next          = count_reg;
        push                = 1'b0;
        if (!ready) begin
            rsp.status = ST_NOT_READY;
        end else if (req.operation == OP_ALLOC) begin
            if (count_reg >= CNT_W'(MAX_ALLOCS)) begin
                rsp.status = ST_TOO_MANY;
            end else if (rounded > (SIZE_W+1)'(free_reg)) begin
                rsp.status = ST_NO_MEMORY;
            end else begin
                push              = 1'b1;
                rsp.block_address = top_reg;
                top_next          = top_reg + ADDR_W'(rounded);
                free_next         = free_reg - rounded[SIZE_W-1:0];
                count_next        = count_reg + CNT_W'(1);
            end
        end else begin
            if (req.release_address[1:0] != 2'b00) begin
                rsp.status = ST_MISALIGNED;
            end else if (count_reg == '0 || count_reg > CNT_W'(MAX_ALLOCS) ||
                         owner_stack_reg[top_idx] != owner_in) begin
                rsp.status = ST_WRONG_OWNER;
            end else if (req.release_address < release_floor_reg) begin
                rsp.status = ST_BELOW_FLOOR;
            end else if (top_reg <= req.release_address) begin
                rsp.status = ST_BAD_ORDER;
            end else begin
                count_next = count_dec;
                top_next   = req.release_address;
                free_next  = (sum > (ADDR_W+1)'(FREE_MAX)) ? FREE_MAX : sum[SIZE_W-1:0];
            end
        end
        rsp.free_bytes_left = free_next;
    end

    // Config and state registers; a heap config write reloads the heap
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            heap_enable_reg   <= 1'b0;
            heap_base_reg     <= '0;
            heap_size_reg     <= '0;
            release_floor_reg <= '0;
            top_reg           <= '0;
            free_reg          <= '0;
            count_reg         <= '0;
        end else if (cfg.we) begin
            case (cfg.index)
                CFG_HEAP_ENABLE: begin
                    heap_enable_reg <= cfg.wdata[0];
                    top_reg         <= heap_base_reg;
                    free_reg        <= heap_size_reg;
                    count_reg       <= '0;
                end
                CFG_HEAP_BASE: begin
                    heap_base_reg <= cfg.wdata;
                    top_reg       <= cfg.wdata;
                    free_reg      <= heap_size_reg;
                    count_reg     <= '0;
                end
                CFG_HEAP_SIZE: begin
                    heap_size_reg <= cfg.wdata[SIZE_W-1:0];
                    top_reg       <= heap_base_reg;
                    free_reg      <= cfg.wdata[SIZE_W-1:0];
                    count_reg     <= '0;
                end
                CFG_RELEASE_FLOOR: begin
                    release_floor_reg <= cfg.wdata;
                end
                default: begin
                end
            endcase
        end else if (fire) begin
            top_reg   <= top_next;
            free_reg  <= free_next;
            count_reg <= count_next;
        end
    end

    // Owner stack: no reset, only entries below the count are read
    always_ff @(posedge aclk) begin
        if (fire && push) begin
            owner_stack_reg[count_reg[IDX_W-1:0]] <= owner_in;
        end
    end

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_W'(MAX_ALLOCS))
        else $error("live count above stack depth");

    a_push_count: assert property (@(posedge aclk) disable iff (!aresetn)
        fire && !cfg.we && push |=> count_reg == CNT_W'($past(count_reg) + CNT_W'(1)))
        else $error("successful allocate did not bump the count");

    a_alloc_free: assert property (@(posedge aclk) disable iff (!aresetn)
        fire && !cfg.we && req.operation == OP_ALLOC |=> free_reg <= $past(free_reg))
        else $error("allocate grew the free space");

    a_fail_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        fire && !cfg.we && rsp.status != ST_OK |=> $stable(top_reg) && $stable(count_reg))
        else $error("failed request changed the heap state");
`endif

endmodule

`default_nettype wire

// ===== design/lifo_region_allocator.sv =====
// Top level of the LIFO region allocator: stream ports, request register, result register.
// Instantiates lra_core; uses lra_pkg.
`default_nettype none

// A stack allocator over one memory region. Each request on the s_ stream
// (allocate or release, selected by s_tuser) yields exactly one result on the
// m_ stream with a status, the granted address and the free bytes left.
// A request is captured in an input register, decided there by
// compare/add logic against the heap state, and written to the result
// register once that register is free; one request per cycle is sustained,
// limited only by the result register draining. Configuration writes on the
// cfg_ port reload the heap (indexes 0..2) or set the release floor (index 3)
// and must be issued while no request is in flight.
module lifo_region_allocator (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    // Configuration write port
    input  wire logic                          cfg_we,
    input  wire logic [lra_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [lra_pkg::CFG_DATA_W-1:0] cfg_wdata,
    // Request stream
    input  wire logic                          s_tvalid,
    output logic                               s_tready,
    // owner_id[7:0], request_size[30:8], release_address[62:31], zero pad [63]
    input  wire logic [lra_pkg::S_TDATA_W-1:0] s_tdata,
    // operation (0 allocate, 1 release)
    input  wire logic                          s_tuser,
    // Result stream
    output logic                               m_tvalid,
    input  wire logic                          m_tready,
    // status[2:0], block_address[34:3], free_bytes_left[57:35], zero pad [63:58]
    output logic [lra_pkg::M_TDATA_W-1:0]      m_tdata
);
    import lra_pkg::*;

    logic    in_valid_reg;
    req_t    in_req_reg;
    logic    out_valid_reg;
    rsp_t    out_rsp_reg;
    rsp_t    core_rsp;
    cfg_wr_t cfg;
    logic    out_free;
    logic    advance;

    assign cfg      = '{we: cfg_we, index: cfg_index, wdata: cfg_wdata};
    assign out_free = !out_valid_reg || m_tready;
    assign advance  = in_valid_reg && out_free;
    assign s_tready = !in_valid_reg || advance;

    // Request register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            in_req_reg.operation       <= op_t'(s_tuser);
            in_req_reg.owner_id        <= s_tdata[7:0];
            in_req_reg.request_size    <= s_tdata[30:8];
            in_req_reg.release_address <= s_tdata[62:31];
        end
    end

    lra_core u_core (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cfg     (cfg),
        .fire    (advance),
        .req     (in_req_reg),
        .rsp     (core_rsp)
    );

    // Result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (out_free) begin
            out_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            out_rsp_reg <= core_rsp;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {6'b0, out_rsp_reg.free_bytes_left, out_rsp_reg.block_address,
                       out_rsp_reg.status};

`ifndef SYNTHESIS
    a_stall_cause: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> in_valid_reg && out_valid_reg && !m_tready)
        else $error("request side stalled without a blocked result");

    a_advance_out: assert property (@(posedge aclk) disable iff (!aresetn)
        advance |=> m_tvalid)
        else $error("decided request produced no result");

    a_held_result: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> $stable(out_rsp_reg))
        else $error("pending result overwritten");
`endif

endmodule

`default_nettype wire
